// ===== hdl/neighbor_count_3x3_core_assert.svh =====
// Assertion macros shared by the neighbor count checker.
// Expects clk_i and rst_ni in the scope where the macros are used.
`ifndef NEIGHBOR_COUNT_3X3_CORE_ASSERT_SVH
`define NEIGHBOR_COUNT_3X3_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define NC3_ASSERT_IMP(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define NC3_ASSERT_NXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/nc3_pkg.sv =====
// Package for the 3x3 neighbor count core: sizes, characters, register indexes.
// No dependencies.
`default_nettype none

package nc3_pkg;

  // Line store depth and derived widths
  localparam int unsigned COLS_MAX = 1024;
  localparam int unsigned PTR_W    = $clog2(COLS_MAX);
  localparam int unsigned CNT_W    = $clog2(COLS_MAX + 3);
  localparam int unsigned NCOLS_W  = 11;
  localparam int unsigned ROW_W    = 16;
  localparam int unsigned CMP_W    = (CNT_W > NCOLS_W) ? CNT_W : NCOLS_W;

  // Characters
  localparam logic [7:0] MINE_CHAR  = 8'd42;
  localparam logic [7:0] BLANK_CHAR = 8'd32;
  localparam logic [7:0] ONE_CHAR   = 8'd49;
  localparam logic [7:0] EIGHT_CHAR = 8'd56;

  // Neighbor masks over the 3x3 window (center is bit 4)
  localparam logic [8:0] MASK_ALL   = 9'h1EF;
  localparam logic [8:0] MASK_TOP   = 9'h124;
  localparam logic [8:0] MASK_BOT   = 9'h049;
  localparam logic [8:0] MASK_LEFT  = 9'h1C0;
  localparam logic [8:0] MASK_RIGHT = 9'h007;

  // Configuration register indexes
  typedef enum logic {
    REG_NUM_COLS = 1'b0,
    REG_NUM_ROWS = 1'b1
  } cfg_reg_e;

  // Reset values of the registers
  localparam logic [NCOLS_W-1:0] NUM_COLS_RST = NCOLS_W'(8);
  localparam logic [ROW_W-1:0]   NUM_ROWS_RST = ROW_W'(8);

endpackage

`default_nettype wire

// ===== hdl/neighbor_count_3x3_core.sv =====
// Top level of the 3x3 neighbor count (mine annotation) core.
// Depends on nc3_pkg; line stores are a local 2-bit wide memory.
//
// Channel  Dir  Handshake                 Payload
// in       in   in_valid_i / in_ready_o   is_pad_i, cell_char_i
// out      out  out_valid_o / out_ready_i out_char_o, row_end_o, frame_end_o
// cfg      in   cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One word per cycle in and out unless stalled. An accepted word waits in the input
// register, then passes window, count and pointer logic into the result register.
// Results trail input by num_cols+1 cells; pad words flush the tail of a frame.
// Line store read data is prefetched one push ahead; a fill count marks written
// entries, so no clearing pass runs after reset. A config write stalls the input
// register in the next cycle. A stalled result register holds it and in_ready_o.
`default_nettype none

module neighbor_count_3x3_core (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // input words
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  wire                             is_pad_i,
  input  wire  [7:0]                      cell_char_i,
  // result words
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output logic [7:0]                      out_char_o,
  output logic                            row_end_o,
  output logic                            frame_end_o,
  // configuration writes
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire                             cfg_index_i,
  input  wire  [nc3_pkg::ROW_W-1:0]       cfg_data_i
);

  import nc3_pkg::*;

  // Count of set bits in a masked window
  function automatic logic [3:0] count9(input logic [8:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 9; i++) begin
      n = n + {3'b000, v[i]};
    end
    return n;
  endfunction

  // Configuration
  logic [NCOLS_W-1:0] num_cols_q, num_cols_d;
  logic [ROW_W-1:0]   num_rows_q, num_rows_d;
  logic               cfg_fire;
  logic               rd_ok_q;
  logic [CNT_W-1:0]   cols_eff;
  logic [ROW_W-1:0]   rows_eff;
  logic [CMP_W-1:0]   cols_ext;

  // Input register
  logic s1_valid_q, s1_pad_q, s1_mine_q;
  logic s1_fire, pad_skip, push;

  // Line store
  logic [1:0]       mem [COLS_MAX];
  logic [1:0]       mem_rd_q, byp_data_q, rd_word, wdata;
  logic             byp_q, byp_d, rd_valid_q, rd_valid_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, wr_eff, wr_nxt, rd_addr;
  logic [CNT_W-1:0] wr_inc, fill_q, fill_d;
  logic             up_bit, mid_bit, new_bit;

  // Window and positions
  logic [8:0]       window_q, window_d;
  logic [ROW_W-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic [PTR_W-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [CNT_W-1:0] lag_q, lag_d;
  logic             drain_q, drain_d;

  // Result register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_char_q, out_char_d;
  logic       row_end_q, row_end_d, frame_end_q, frame_end_d;
  logic       emit, rend, fend;
  logic [8:0] mask;
  logic [3:0] ncount;

  // Effective sizes: columns clamped to 1..COLS_MAX, zero rows read as one
  assign cols_ext = (num_cols_q == '0) ? CMP_W'(1) :
                    (CMP_W'(num_cols_q) > CMP_W'(COLS_MAX)) ? CMP_W'(COLS_MAX) :
                    CMP_W'(num_cols_q);
  assign cols_eff = cols_ext[CNT_W-1:0];
  assign rows_eff = (num_rows_q == '0) ? ROW_W'(1) : num_rows_q;

  // Config port always ready
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_comb begin
    num_cols_d = num_cols_q;
    num_rows_d = num_rows_q;
    if (cfg_fire) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_NUM_COLS: num_cols_d = cfg_data_i[NCOLS_W-1:0];
        REG_NUM_ROWS: num_rows_d = cfg_data_i;
        default:      num_cols_d = num_cols_q;
      endcase
    end
  end

  // Handshakes
  assign s1_fire    = s1_valid_q && rd_ok_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign pad_skip   = s1_pad_q && ((in_row_q != '0) || (in_col_q != '0) || (lag_q == '0));
  assign push       = s1_fire && !pad_skip;

  // Line store addressing: read is prefetched for the next push
  assign wr_eff  = (CNT_W'(wr_ptr_q) >= cols_eff) ? '0 : wr_ptr_q;
  assign wr_inc  = CNT_W'(wr_eff) + CNT_W'(1);
  assign wr_nxt  = (wr_inc >= cols_eff) ? '0 : wr_inc[PTR_W-1:0];
  assign rd_addr = push ? wr_nxt : wr_eff;
  assign rd_word = byp_q ? byp_data_q : (rd_valid_q ? mem_rd_q : 2'b00);
  assign up_bit  = rd_word[1];
  assign mid_bit = rd_word[0];
  assign new_bit = !s1_pad_q && s1_mine_q;
  assign wdata   = {mid_bit, new_bit};

  assign wr_ptr_d   = push ? wr_nxt : wr_ptr_q;
  assign fill_d     = (push && (CNT_W'(wr_eff) >= fill_q)) ? wr_inc : fill_q;
  assign rd_valid_d = CNT_W'(rd_addr) < fill_d;
  assign byp_d      = push && (rd_addr == wr_eff);

  // Line store memory, upper bit in [1], middle bit in [0]
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_eff] <= wdata;
    end
    mem_rd_q   <= mem[rd_addr];
    byp_data_q <= wdata;
  end

  // Window, position and result logic
  always_comb begin
    window_d    = window_q;
    in_row_d    = in_row_q;
    in_col_d    = in_col_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    lag_d       = lag_q;
    drain_d     = drain_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_char_d  = out_char_q;
    row_end_d   = row_end_q;
    frame_end_d = frame_end_q;
    emit        = 1'b0;
    rend        = 1'b0;
    fend        = 1'b0;
    mask        = MASK_ALL;
    ncount      = 4'd0;

    if (push) begin
      // a cell after a pad drain restarts the output side
      if (!s1_pad_q && drain_q) begin
        lag_d     = '0;
        out_row_d = '0;
        out_col_d = '0;
        drain_d   = 1'b0;
      end
      if (s1_pad_q) begin
        drain_d = 1'b1;
      end
      lag_d    = lag_d + CNT_W'(1);
      window_d = {window_q[5:0], up_bit, mid_bit, new_bit};

      // input position
      if (!s1_pad_q) begin
        if ((CNT_W'(in_col_q) + CNT_W'(1)) >= cols_eff) begin
          in_col_d = '0;
          in_row_d = (({1'b0, in_row_q} + 17'd1) >= {1'b0, rows_eff}) ? '0 :
                     in_row_q + ROW_W'(1);
        end else begin
          in_col_d = in_col_q + PTR_W'(1);
        end
      end

      // result for the cell at the output position
      emit = {1'b0, lag_d} >= ({1'b0, cols_eff} + (CNT_W+1)'(2));
      if (emit) begin
        rend = (CNT_W'(out_col_d) + CNT_W'(1)) >= cols_eff;
        fend = rend && (({1'b0, out_row_d} + 17'd1) >= {1'b0, rows_eff});
        if (out_row_d == '0) mask = mask & ~MASK_TOP;
        if (({1'b0, out_row_d} + 17'd1) >= {1'b0, rows_eff}) mask = mask & ~MASK_BOT;
        if (out_col_d == '0) mask = mask & ~MASK_LEFT;
        if (rend) mask = mask & ~MASK_RIGHT;
        ncount = count9(window_d & mask);

        out_valid_d = 1'b1;
        row_end_d   = rend;
        frame_end_d = fend;
        if (window_d[4]) begin
          out_char_d = MINE_CHAR;
        end else if (ncount == 4'd0) begin
          out_char_d = BLANK_CHAR;
        end else begin
          out_char_d = (ONE_CHAR - 8'd1) + {4'b0000, ncount};
        end

        lag_d = cols_eff + CNT_W'(1);
        if (rend) begin
          out_col_d = '0;
          out_row_d = (({1'b0, out_row_d} + 17'd1) >= {1'b0, rows_eff}) ? '0 :
                      out_row_d + ROW_W'(1);
        end else begin
          out_col_d = out_col_d + PTR_W'(1);
        end
        if (fend && drain_d) begin
          lag_d   = '0;
          drain_d = 1'b0;
        end
      end
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cols_q  <= NUM_COLS_RST;
      num_rows_q  <= NUM_ROWS_RST;
      rd_ok_q     <= 1'b1;
      s1_valid_q  <= 1'b0;
      wr_ptr_q    <= '0;
      fill_q      <= '0;
      byp_q       <= 1'b0;
      rd_valid_q  <= 1'b0;
      window_q    <= '0;
      in_row_q    <= '0;
      in_col_q    <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      lag_q       <= '0;
      drain_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      num_cols_q  <= num_cols_d;
      num_rows_q  <= num_rows_d;
      rd_ok_q     <= !cfg_fire;
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      wr_ptr_q    <= wr_ptr_d;
      fill_q      <= fill_d;
      byp_q       <= byp_d;
      rd_valid_q  <= rd_valid_d;
      window_q    <= window_d;
      in_row_q    <= in_row_d;
      in_col_q    <= in_col_d;
      out_row_q   <= out_row_d;
      out_col_q   <= out_col_d;
      lag_q       <= lag_d;
      drain_q     <= drain_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      s1_pad_q  <= is_pad_i;
      s1_mine_q <= (cell_char_i == MINE_CHAR);
    end
    out_char_q  <= out_char_d;
    row_end_q   <= row_end_d;
    frame_end_q <= frame_end_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign row_end_o   = row_end_q;
  assign frame_end_o = frame_end_q;

endmodule

`default_nettype wire

// ===== hdl/nc3_checker.sv =====
// Port-level checker for neighbor_count_3x3_core, bound to the top level.
// Depends on nc3_pkg and neighbor_count_3x3_core_assert.svh.
`default_nettype none

`include "neighbor_count_3x3_core_assert.svh"

module nc3_checker (
  input wire                       clk_i,
  input wire                       rst_ni,
  input wire                       in_valid_i,
  input wire                       in_ready_o,
  input wire                       is_pad_i,
  input wire [7:0]                 cell_char_i,
  input wire                       out_valid_o,
  input wire                       out_ready_i,
  input wire [7:0]                 out_char_o,
  input wire                       row_end_o,
  input wire                       frame_end_o,
  input wire                       cfg_valid_i,
  input wire                       cfg_ready_o,
  input wire                       cfg_index_i,
  input wire [nc3_pkg::ROW_W-1:0]  cfg_data_i
);

  import nc3_pkg::*;

  logic unused_ok;
  assign unused_ok = ^{in_valid_i, in_ready_o, is_pad_i, cell_char_i,
                       cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i};

  // A stalled result word holds
  `NC3_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_char_o) && $stable(row_end_o) && $stable(frame_end_o),
    "result word changed while stalled")

  // Result character is a mine, a blank or a digit one to eight
  `NC3_ASSERT_IMP(a_out_char, out_valid_o,
    (out_char_o == MINE_CHAR) || (out_char_o == BLANK_CHAR) ||
    ((out_char_o >= ONE_CHAR) && (out_char_o <= EIGHT_CHAR)),
    "illegal result character")

  // The last cell of a frame is also the last of its row
  `NC3_ASSERT_IMP(a_frame_row, out_valid_o && frame_end_o, row_end_o,
    "frame end without row end")

endmodule

bind neighbor_count_3x3_core nc3_checker u_nc3_checker (.*);

`default_nettype wire
